// ===== src/abcd_pkg.sv =====
// Shared types and constants for the 8-bit ALU with BCD add and subtract.
// Holds the transfer payload structs, operation codes and pipeline stage records.
// Depends on nothing; every other file imports it.
package abcd_pkg;

    localparam int NUM_STAGES = 3;

    typedef enum logic [3:0] {
        FN_AND = 4'd0,
        FN_ORA = 4'd1,
        FN_EOR = 4'd2,
        FN_BIT = 4'd3,
        FN_ADC = 4'd4,
        FN_SBC = 4'd5,
        FN_CMP = 4'd6,
        FN_INC = 4'd7,
        FN_DEC = 4'd8,
        FN_ASL = 4'd9,
        FN_LSR = 4'd10,
        FN_ROL = 4'd11,
        FN_ROR = 4'd12
    } alu_func_t;

    localparam logic [4:0] BCD_DIGIT_MAX = 5'h09;
    localparam logic [3:0] BCD_ADJ_LO    = 4'h6;
    localparam logic [7:0] BCD_ADJ_HI    = 8'h60;
    localparam logic [8:0] HI_DIGIT_ONE  = 9'h010;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] reg_value;
        logic [7:0] operand;
        logic       carry_in;
        logic       overflow_in;
        logic       decimal;
    } in_t;

    typedef struct packed {
        logic [7:0] result;
        logic       negative;
        logic       overflow;
        logic       zero;
        logic       carry;
    } out_t;

    // Raw sums and differences formed in the first stage.
    typedef struct packed {
        logic [3:0] func;
        logic [7:0] a;
        logic [7:0] o;
        logic       cin;
        logic       vin;
        logic       dec;
        logic [8:0] sum;
        logic [8:0] diff;
        logic [8:0] cmp_diff;
        logic [4:0] add_lo;
        logic [4:0] add_hi;
        logic [4:0] sub_lo;
        logic [8:0] sub_hi;
        logic [8:0] sub_hi_dec;
    } s1_t;

    // Nearly final result; decimal add still needs its high digit adjust.
    typedef struct packed {
        out_t       res;
        logic       bcd_add;
        logic [8:0] bcd_sum;
    } s2_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

endpackage

// ===== src/alu_8bit_bcd_with_flags_core.sv =====
// Top level of the 8-bit ALU with NMOS-style BCD add and subtract and N, V, Z, C flags.
// Three register stages: raw sums, digit adjust and flag selection, final BCD adjust.
// Depends on abcd_pkg and abcd_pipe_ctrl.

// The block accepts one operation per clock cycle while op_stall is low and passes it
// through its three register stages, s1_reg, s2_reg and out_reg, in turn. Operations and results
// keep their order, and a stall on the result side backs up through the stages,
// filling any empty ones before the input side stalls.
module alu_8bit_bcd_with_flags_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_stall,
    input  abcd_pkg::in_t  op_data,
    output logic           res_valid,
    input  logic           res_stall,
    output abcd_pkg::out_t res_data
);
    import abcd_pkg::*;

    pipe_ctrl_t ctrl;
    s1_t        s1_reg;
    s1_t        s1_next;
    s2_t        s2_reg;
    s2_t        s2_next;
    out_t       out_reg;
    out_t       out_next;

    abcd_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .res_stall (res_stall),
        .ctrl      (ctrl)
    );

    // Stage one: binary sums and per-digit sums and differences.
    always_comb
    begin
        s1_next.func       = op_data.func;
        s1_next.a          = op_data.reg_value;
        s1_next.o          = op_data.operand;
        s1_next.cin        = op_data.carry_in;
        s1_next.vin        = op_data.overflow_in;
        s1_next.dec        = op_data.decimal;
        s1_next.sum        = {1'b0, op_data.reg_value} + {1'b0, op_data.operand}
                           + {8'd0, op_data.carry_in};
        s1_next.diff       = {1'b0, op_data.reg_value} - {1'b0, op_data.operand}
                           - {8'd0, !op_data.carry_in};
        s1_next.cmp_diff   = {1'b0, op_data.reg_value} - {1'b0, op_data.operand};
        s1_next.add_lo     = {1'b0, op_data.reg_value[3:0]} + {1'b0, op_data.operand[3:0]}
                           + {4'd0, op_data.carry_in};
        s1_next.add_hi     = {1'b0, op_data.reg_value[7:4]} + {1'b0, op_data.operand[7:4]};
        s1_next.sub_lo     = {1'b0, op_data.reg_value[3:0]} - {1'b0, op_data.operand[3:0]}
                           - {4'd0, !op_data.carry_in};
        s1_next.sub_hi     = {1'b0, op_data.reg_value[7:4], 4'd0}
                           - {1'b0, op_data.operand[7:4], 4'd0};
        s1_next.sub_hi_dec = {1'b0, op_data.reg_value[7:4], 4'd0}
                           - {1'b0, op_data.operand[7:4], 4'd0} - HI_DIGIT_ONE;
    end

    // Stage two: operation select, flags, the low digit adjusts and the whole decimal subtract adjust.
    always_comb
    begin
        logic [5:0] lo_adj;
        logic       lo_carry;
        logic [8:0] hi_sel;
        logic [3:0] lo_digit;
        logic [7:0] bcd_diff;
        logic [7:0] r;

        lo_adj   = (s1_reg.add_lo > BCD_DIGIT_MAX) ? ({1'b0, s1_reg.add_lo} + 6'd6)
                                                   : {1'b0, s1_reg.add_lo};
        lo_carry = |lo_adj[5:4];
        hi_sel   = s1_reg.sub_lo[4] ? s1_reg.sub_hi_dec : s1_reg.sub_hi;
        lo_digit = s1_reg.sub_lo[4] ? (s1_reg.sub_lo[3:0] - BCD_ADJ_LO) : s1_reg.sub_lo[3:0];
        bcd_diff = hi_sel[8] ? ({hi_sel[7:4], lo_digit} - BCD_ADJ_HI) : {hi_sel[7:4], lo_digit};

        s2_next.bcd_add = 1'b0;
        s2_next.bcd_sum = {s1_reg.add_hi + {4'd0, lo_carry}, lo_adj[3:0]};
        r               = s1_reg.a;
        s2_next.res.result   = s1_reg.a;
        s2_next.res.negative = s1_reg.a[7];
        s2_next.res.overflow = s1_reg.vin;
        s2_next.res.zero     = (s1_reg.a == 8'd0);
        s2_next.res.carry    = s1_reg.cin;

        case (s1_reg.func)
            FN_AND, FN_ORA, FN_EOR, FN_INC, FN_DEC, FN_ASL, FN_LSR, FN_ROL, FN_ROR:
            begin
                case (s1_reg.func)
                    FN_AND:  r = s1_reg.a & s1_reg.o;
                    FN_ORA:  r = s1_reg.a | s1_reg.o;
                    FN_EOR:  r = s1_reg.a ^ s1_reg.o;
                    FN_INC:  r = s1_reg.o + 8'd1;
                    FN_DEC:  r = s1_reg.o - 8'd1;
                    FN_ASL:  r = {s1_reg.o[6:0], 1'b0};
                    FN_LSR:  r = {1'b0, s1_reg.o[7:1]};
                    FN_ROL:  r = {s1_reg.o[6:0], s1_reg.cin};
                    FN_ROR:  r = {s1_reg.cin, s1_reg.o[7:1]};
                    default: r = s1_reg.a;
                endcase
                s2_next.res.result   = r;
                s2_next.res.negative = r[7];
                s2_next.res.zero     = (r == 8'd0);
                if (s1_reg.func == FN_ASL || s1_reg.func == FN_ROL)
                begin
                    s2_next.res.carry = s1_reg.o[7];
                end
                else if (s1_reg.func == FN_LSR || s1_reg.func == FN_ROR)
                begin
                    s2_next.res.carry = s1_reg.o[0];
                end
            end
            FN_BIT:
            begin
                s2_next.res.negative = s1_reg.o[7];
                s2_next.res.overflow = s1_reg.o[6];
                s2_next.res.zero     = ((s1_reg.a & s1_reg.o) == 8'd0);
            end
            FN_ADC:
            begin
                s2_next.res.zero = (s1_reg.sum[7:0] == 8'd0);
                if (s1_reg.dec)
                begin
                    s2_next.bcd_add      = 1'b1;
                    s2_next.res.negative = s2_next.bcd_sum[7];
                    s2_next.res.overflow = (s1_reg.a[7] ^ s2_next.bcd_sum[7])
                                         && !(s1_reg.a[7] ^ s1_reg.o[7]);
                end
                else
                begin
                    s2_next.res.result   = s1_reg.sum[7:0];
                    s2_next.res.negative = s1_reg.sum[7];
                    s2_next.res.overflow = !(s1_reg.a[7] ^ s1_reg.o[7])
                                         && (s1_reg.a[7] ^ s1_reg.sum[7]);
                    s2_next.res.carry    = s1_reg.sum[8];
                end
            end
            FN_SBC:
            begin
                s2_next.res.result   = s1_reg.dec ? bcd_diff : s1_reg.diff[7:0];
                s2_next.res.negative = s1_reg.diff[7];
                s2_next.res.overflow = (s1_reg.a[7] ^ s1_reg.diff[7])
                                     && (s1_reg.a[7] ^ s1_reg.o[7]);
                s2_next.res.zero     = (s1_reg.diff[7:0] == 8'd0);
                s2_next.res.carry    = !s1_reg.diff[8];
            end
            FN_CMP:
            begin
                s2_next.res.negative = s1_reg.cmp_diff[7];
                s2_next.res.zero     = (s1_reg.a == s1_reg.o);
                s2_next.res.carry    = !s1_reg.cmp_diff[8];
            end
            default:
            begin
                s2_next.res.result = s1_reg.a;
            end
        endcase
    end

    // Stage three: high digit adjust and carry of the decimal add.
    always_comb
    begin
        logic [9:0] adj;

        adj      = (s2_reg.bcd_sum[8:4] > BCD_DIGIT_MAX)
                 ? ({1'b0, s2_reg.bcd_sum} + {2'b00, BCD_ADJ_HI})
                 : {1'b0, s2_reg.bcd_sum};
        out_next = s2_reg.res;
        if (s2_reg.bcd_add)
        begin
            out_next.result = adj[7:0];
            out_next.carry  = |adj[9:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            s1_reg <= s1_next;
        end
        if (ctrl.load[1])
        begin
            s2_reg <= s2_next;
        end
        if (ctrl.load[2])
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = ctrl.valid[NUM_STAGES-1];
    assign res_data  = out_reg;

endmodule

// ===== src/abcd_pipe_ctrl.sv =====
// Valid bits and load enables for the ALU pipeline stages.
// A stage loads when it is empty or its contents move on, so bubbles collapse.
// Depends on abcd_pkg.
module abcd_pipe_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    output logic                op_stall,
    input  logic                res_stall,
    output abcd_pkg::pipe_ctrl_t ctrl
);
    import abcd_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;
    logic [NUM_STAGES-1:0] load;

    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !res_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        load[0] = ready[0] && op_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            load[k] = ready[k] && valid_reg[k-1];
        end
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = 1'b1;
            end
            else if (ready[k])
            begin
                valid_next[k] = 1'b0;
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign op_stall   = !ready[0];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 8-bit ALU core with NMOS-style BCD add and subtract.
// Drives a directed table, then random operations; checks results against the table or predictor.
// Depends on abcd_pkg and the alu_8bit_bcd_with_flags_core top level.
module testbench;
    import abcd_pkg::*;

    localparam logic [3:0] FN_SPARE_FIRST = 4'd13;
    localparam logic [3:0] FN_SPARE_MID   = 4'd14;
    localparam logic [3:0] FN_SPARE_LAST  = 4'd15;
    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM   = 1650;
    localparam int PIPE_DEPTH   = 3;

    typedef struct packed {
        logic check;
        in_t  stim;
        out_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic op_valid = 1'b0;
    logic op_stall;
    in_t  op_data = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    out_t res_data;

    out_t pending_results[$];
    int   error_count = 0;
    bit   quiet_ops = 1'b0;
    bit   quiet_res = 1'b0;

    directed_row_t directed_table [NUM_DIRECTED] = '{
        '{1'b1, '{FN_AND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{1'b1, '{FN_ORA, 8'h80, 8'h01, 1'b0, 1'b0, 1'b0}, '{8'h81, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{1'b1, '{FN_EOR, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{1'b1, '{FN_BIT, 8'h0F, 8'hC0, 1'b1, 1'b0, 1'b0}, '{8'h0F, 1'b1, 1'b1, 1'b1, 1'b1}},
        '{1'b1, '{FN_ADC, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{1'b1, '{FN_ADC, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{1'b0, '{FN_ADC, 8'h99, 8'h01, 1'b0, 1'b0, 1'b1}, '0},
        '{1'b0, '{FN_ADC, 8'h58, 8'h46, 1'b1, 1'b0, 1'b1}, '0},
        '{1'b0, '{FN_ADC, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1}, '0},
        '{1'b1, '{FN_SBC, 8'h00, 8'h01, 1'b1, 1'b1, 1'b0}, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{1'b1, '{FN_SBC, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0}, '{8'h7F, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{1'b0, '{FN_SBC, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1}, '0},
        '{1'b0, '{FN_SBC, 8'hAA, 8'hFF, 1'b0, 1'b1, 1'b1}, '0},
        '{1'b1, '{FN_CMP, 8'h40, 8'h40, 1'b0, 1'b1, 1'b0}, '{8'h40, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{1'b1, '{FN_CMP, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{1'b1, '{FN_INC, 8'h55, 8'hFF, 1'b1, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{1'b1, '{FN_DEC, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{1'b1, '{FN_ASL, 8'hFF, 8'h80, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1}},
        '{1'b1, '{FN_LSR, 8'h00, 8'h01, 1'b0, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1}},
        '{1'b1, '{FN_ROL, 8'h00, 8'h80, 1'b1, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{1'b1, '{FN_ROR, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0}, '{8'h80, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{1'b1, '{FN_SPARE_FIRST, 8'h00, 8'hFF, 1'b0, 1'b1, 1'b0},
            '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{1'b1, '{FN_SPARE_MID, 8'h80, 8'h00, 1'b1, 1'b0, 1'b0},
            '{8'h80, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{1'b0, '{FN_SPARE_LAST, 8'h7F, 8'hFF, 1'b1, 1'b1, 1'b1}, '0}
    };

    alu_8bit_bcd_with_flags_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op_data   (op_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

    function automatic out_t alu_predict(in_t op);
        logic [7:0]  a;
        logic [7:0]  o;
        logic [7:0]  r8;
        logic [31:0] a32;
        logic [31:0] o32;
        logic [31:0] c32;
        logic [31:0] sum;
        logic [31:0] diff;
        logic [31:0] lo;
        logic [31:0] dd;
        out_t        res;
        a = op.reg_value;
        o = op.operand;
        a32 = {24'd0, a};
        o32 = {24'd0, o};
        c32 = {31'd0, op.carry_in};
        res.overflow = op.overflow_in;
        res.carry = op.carry_in;
        case (op.func)
            FN_AND: r8 = a & o;
            FN_ORA: r8 = a | o;
            FN_EOR: r8 = a ^ o;
            FN_INC: r8 = o + 8'd1;
            FN_DEC: r8 = o - 8'd1;
            FN_ASL:
            begin
                r8 = {o[6:0], 1'b0};
                res.carry = o[7];
            end
            FN_LSR:
            begin
                r8 = {1'b0, o[7:1]};
                res.carry = o[0];
            end
            FN_ROL:
            begin
                r8 = {o[6:0], op.carry_in};
                res.carry = o[7];
            end
            FN_ROR:
            begin
                r8 = {op.carry_in, o[7:1]};
                res.carry = o[0];
            end
            default: r8 = a;
        endcase
        res.result = r8;
        res.negative = r8[7];
        res.zero = (r8 == 8'd0);
        case (op.func)
            FN_BIT:
            begin
                res.negative = o[7];
                res.overflow = o[6];
                res.zero = ((a & o) == 8'd0);
            end
            FN_CMP:
            begin
                r8 = a - o;
                res.negative = r8[7];
                res.zero = (a == o);
                res.carry = (a >= o);
            end
            FN_ADC:
            begin
                sum = a32 + o32 + c32;
                res.zero = (sum[7:0] == 8'd0);
                if (!op.decimal)
                begin
                    res.result = sum[7:0];
                    res.negative = sum[7];
                    res.overflow = ~(a[7] ^ o[7]) & (a[7] ^ sum[7]);
                    res.carry = sum[8];
                end
                else
                begin
                    lo = (a32 & 32'h0F) + (o32 & 32'h0F) + c32;
                    if (lo > 32'h09)
                        lo = lo + 32'h06;
                    dd = (lo & 32'h0F) + (a32 & 32'hF0) + (o32 & 32'hF0)
                        + ((lo > 32'h0F) ? 32'h10 : 32'h0);
                    res.overflow = (a[7] ^ dd[7]) && !(a[7] ^ o[7]);
                    res.negative = dd[7];
                    if ((dd & 32'h1F0) > 32'h90)
                        dd = dd + 32'h60;
                    res.carry = ((dd & 32'hFF0) > 32'hF0);
                    res.result = dd[7:0];
                end
            end
            FN_SBC:
            begin
                diff = a32 - o32 - (c32 ^ 32'd1);
                res.overflow = (((a32 ^ diff) & 32'h80) != 0) && (((a32 ^ o32) & 32'h80) != 0);
                res.carry = !diff[8];
                res.negative = diff[7];
                res.zero = (diff[7:0] == 8'd0);
                res.result = diff[7:0];
                if (op.decimal)
                begin
                    dd = (a32 & 32'h0F) - (o32 & 32'h0F) - (c32 ^ 32'd1);
                    if (dd[4])
                        dd = ((dd - 32'd6) & 32'h0F) | ((a32 & 32'hF0) - (o32 & 32'hF0) - 32'h10);
                    else
                        dd = (dd & 32'h0F) | ((a32 & 32'hF0) - (o32 & 32'hF0));
                    if (dd[8])
                        dd = dd - 32'h60;
                    res.result = dd[7:0];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 4)];
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] random_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic in_t random_op();
        in_t op;
        if ($urandom_range(0, 39) == 0)
            op.func = 4'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
        else
            op.func = 4'($urandom_range(FN_AND, FN_ROR));
        op.carry_in = 1'($urandom);
        op.overflow_in = 1'($urandom);
        op.decimal = 1'($urandom);
        if (op.decimal && (op.func == FN_ADC || op.func == FN_SBC)
            && $urandom_range(0, 2) != 0)
        begin
            op.reg_value = random_bcd();
            op.operand = random_bcd();
        end
        else
        begin
            op.reg_value = random_byte();
            op.operand = random_byte();
        end
        return op;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // A transfer is complete at the first edge where op_valid is high and op_stall is low.
    task automatic send_op(input in_t op, input out_t want);
        int gap;
        if ($urandom_range(0, 39) == 0)
            quiet_ops = !quiet_ops;
        gap = quiet_ops ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            op_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op_valid <= 1'b1;
        op_data <= op;
        do
            @(posedge clk);
        while (op_stall);
        pending_results.push_back(want);
    endtask

    initial
    begin
        int stall_len;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_res = !quiet_res;
            stall_len = quiet_res ? 0 : $urandom_range(0, 18);
            if (stall_len > 0)
            begin
                res_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no operation outstanding: %h", res_data);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("result", want.result, res_data.result);
                check_field("negative", {7'd0, want.negative}, {7'd0, res_data.negative});
                check_field("overflow", {7'd0, want.overflow}, {7'd0, res_data.overflow});
                check_field("zero", {7'd0, want.zero}, {7'd0, res_data.zero});
                check_field("carry", {7'd0, want.carry}, {7'd0, res_data.carry});
            end
        end
    end

    initial
    begin
        in_t op;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_table[i])
            send_op(directed_table[i].stim, directed_table[i].check
                ? directed_table[i].want : alu_predict(directed_table[i].stim));
        repeat (NUM_RANDOM)
        begin
            op = random_op();
            send_op(op, alu_predict(op));
        end
        op_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
